// File: sv/dha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dha_pkg
// Shared types and constants for the delayed hysteresis alarm.
// ----------------------------------------------------------------------------
package dha_pkg;

  // Item command codes
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  // Event codes reported with each result item
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ARM_RISE = 3'd1,  // alarm off, sample above setpoint
    EV_ARM_HIGH = 3'd2,  // alarm on, peak above upper band, sample below setpoint
    EV_ARM_BAND = 3'd3,  // alarm on, peak between setpoint and upper band, sample below lower band
    EV_TOGGLE   = 3'd4
  } event_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SETPOINT = 2'd0;
  localparam logic [1:0] CFG_DELAY    = 2'd1;
  localparam logic [1:0] CFG_DEVIATION = 2'd2;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned ElapsedWidth = 17;
  localparam logic [ElapsedWidth-1:0] ElapsedMax = '1;

endpackage : dha_pkg
`default_nettype wire

// File: sv/delayed_hysteresis_alarm.sv
`default_nettype none
// Result: an accepted item's result is on the output register in the cycle after acceptance.
// Throughput: one item per cycle; the state update and the compares sit in one
//   register-to-register pass, and input stalls only while a result waits.
// Reset: rst_ni clears the alarm, timer, peak, previous sample, the
//   configuration registers and the output valid at once.
// ----------------------------------------------------------------------------
// delayed_hysteresis_alarm
// Setpoint alarm with hysteresis band and tick-counted toggle delay.
// ----------------------------------------------------------------------------
module delayed_hysteresis_alarm #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write port
  input  wire                                 cfg_we_i,
  input  wire  [1:0]                          cfg_idx_i,
  input  wire  [dha_pkg::CfgDataWidth-1:0]    cfg_data_i,
  // input channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 cmd_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_i,
  // output channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                alarm_o,
  output logic                                timer_armed_o,
  output logic [2:0]                          event_res_o
);
  import dha_pkg::*;

  // compare width covers the sample and setpoint +/- deviation without wrap
  localparam int unsigned CmpWidth = ((SAMPLE_WIDTH > 17) ? SAMPLE_WIDTH : 17) + 1;

  // configuration registers
  logic signed [15:0]         setpoint_q;
  logic        [15:0]         delay_q;
  logic        [14:0]         deviation_q;

  // block state
  logic                       alarm_q, alarm_d;
  logic                       armed_q, armed_d;
  logic [ElapsedWidth-1:0]    elapsed_q, elapsed_d;
  logic signed [SAMPLE_WIDTH-1:0] peak_q, peak_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_q, prev_d;

  // result register
  logic                       out_valid_q;
  logic                       res_alarm_q, res_armed_q;
  event_e                     res_event_q, event_d;

  logic                       accept;

  // compare operands
  logic signed [CmpWidth-1:0] s_ext, sp_ext, upper, lower, peak_ext;
  logic signed [SAMPLE_WIDTH-1:0] peak_upd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      delay_q     <= '0;
      deviation_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETPOINT:  setpoint_q  <= cfg_data_i;
        CFG_DELAY:     delay_q     <= cfg_data_i;
        CFG_DEVIATION: deviation_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // band limits and running peak
  always_comb begin
    s_ext    = CmpWidth'(sample_i);
    sp_ext   = CmpWidth'(setpoint_q);
    upper    = sp_ext + $signed({{(CmpWidth-15){1'b0}}, deviation_q});
    lower    = sp_ext - $signed({{(CmpWidth-15){1'b0}}, deviation_q});
    peak_upd = (prev_q > peak_q) ? prev_q : peak_q;
    peak_ext = CmpWidth'(peak_upd);
  end

  // next state and event for one item
  always_comb begin
    alarm_d   = alarm_q;
    armed_d   = armed_q;
    elapsed_d = elapsed_q;
    peak_d    = peak_q;
    prev_d    = prev_q;
    event_d   = EV_NONE;
    if (cmd_i == CMD_SAMPLE) begin
      peak_d = peak_upd;
      prev_d = sample_i;
      if (!armed_q) begin
        if (!alarm_q) begin
          if (s_ext > sp_ext) event_d = EV_ARM_RISE;
        end else if (peak_ext > upper) begin
          if (s_ext < sp_ext) event_d = EV_ARM_HIGH;
        end else if (peak_ext < upper && peak_ext > sp_ext) begin
          if (s_ext < lower) event_d = EV_ARM_BAND;
        end
        if (event_d != EV_NONE) begin
          armed_d   = 1'b1;
          elapsed_d = '0;
          if (event_d != EV_ARM_RISE) peak_d = '0;
        end
      end
    end else if (armed_q) begin
      // saturating tick count, then compare against the delay
      if (elapsed_q != ElapsedMax) elapsed_d = elapsed_q + 1'b1;
      if (elapsed_d > {1'b0, delay_q}) begin
        alarm_d = !alarm_q;
        armed_d = 1'b0;
        event_d = EV_TOGGLE;
      end
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q   <= 1'b0;
      armed_q   <= 1'b0;
      elapsed_q <= '0;
      peak_q    <= '0;
      prev_q    <= '0;
    end else if (accept) begin
      alarm_q   <= alarm_d;
      armed_q   <= armed_d;
      elapsed_q <= elapsed_d;
      peak_q    <= peak_d;
      prev_q    <= prev_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_alarm_q <= alarm_d;
      res_armed_q <= armed_d;
      res_event_q <= event_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign alarm_o       = res_alarm_q;
  assign timer_armed_o = res_armed_q;
  assign event_res_o   = res_event_q;

  // a toggle flips the stored alarm
  a_toggle_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && event_d == EV_TOGGLE) |=> (alarm_q != $past(alarm_q)))
    else $error("toggle event did not flip the alarm");

  // an arming event is reported with the timer running
  a_arm_reports_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_event_q == EV_ARM_RISE || res_event_q == EV_ARM_HIGH ||
                     res_event_q == EV_ARM_BAND)) |-> res_armed_q)
    else $error("arming event without armed timer");

  // a toggle is reported with the timer stopped
  a_toggle_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_event_q == EV_TOGGLE) |-> !res_armed_q)
    else $error("toggle event with timer still armed");

  // arming always restarts the tick count
  a_arm_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !armed_q && armed_d) |=> (elapsed_q == '0))
    else $error("arming did not clear the tick count");

endmodule : delayed_hysteresis_alarm
`default_nettype wire

// File: tb/tb_delayed_hysteresis_alarm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_delayed_hysteresis_alarm
// Self-checking bench for the delayed hysteresis alarm. A clocked driver
// feeds sample and tick items from a queue, a clocked monitor compares every
// result item with a cycle-free model of the alarm, timer and peak tracker.
// Phases change the setpoint, delay and band (extremes included) while the
// block is idle, and vary idling on both channels, with one long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_delayed_hysteresis_alarm;
  import dha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SampleW-1:0] sample;
  } alarm_item_t;

  typedef struct packed {
    logic   alarm;
    logic   armed;
    event_e ev;
  } alarm_res_t;

  // DUT signals
  logic                      clk_i  = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_idx = CFG_SETPOINT;
  logic [CfgDataWidth-1:0]   cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  cmd_e                      in_cmd = CMD_SAMPLE;
  logic signed [SampleW-1:0] in_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      alarm;
  logic                      timer_armed;
  logic [2:0]                event_res;

  // Model state and configuration
  logic                      mdl_alarm   = 1'b0;
  logic                      mdl_armed   = 1'b0;
  logic [ElapsedWidth-1:0]   mdl_elapsed = '0;
  logic signed [SampleW-1:0] mdl_peak    = '0;
  logic signed [SampleW-1:0] mdl_prev    = '0;
  logic signed [15:0]        mdl_setpoint  = '0;
  logic [15:0]               mdl_delay     = '0;
  logic [14:0]               mdl_deviation = '0;

  alarm_item_t pending_items_q[$];
  alarm_res_t  predicted_res_q[$];

  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  delayed_hysteresis_alarm #(
    .SAMPLE_WIDTH(SampleW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (in_cmd),
    .sample_i      (in_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .alarm_o       (alarm),
    .timer_armed_o (timer_armed),
    .event_res_o   (event_res)
  );

  // Clock, 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Alarm model: one result per item, updates the model state
  function automatic alarm_res_t alarm_predict(alarm_item_t it);
    int         upper;
    int         lower;
    event_e     ev;
    alarm_res_t res;
    ev    = EV_NONE;
    upper = int'(mdl_setpoint) + int'(mdl_deviation);
    lower = int'(mdl_setpoint) - int'(mdl_deviation);
    if (it.cmd == CMD_SAMPLE) begin
      if (mdl_prev > mdl_peak) mdl_peak = mdl_prev;
      mdl_prev = it.sample;
      if (!mdl_armed) begin
        if (!mdl_alarm) begin
          if (it.sample > mdl_setpoint) ev = EV_ARM_RISE;
        end else if (int'(mdl_peak) > upper) begin
          if (it.sample < mdl_setpoint) ev = EV_ARM_HIGH;
        end else if (int'(mdl_peak) < upper && mdl_peak > mdl_setpoint) begin
          if (int'(it.sample) < lower) ev = EV_ARM_BAND;
        end
        if (ev != EV_NONE) begin
          mdl_armed   = 1'b1;
          mdl_elapsed = '0;
          if (ev != EV_ARM_RISE) mdl_peak = '0;
        end
      end
    end else if (mdl_armed) begin
      if (mdl_elapsed != ElapsedMax) mdl_elapsed = mdl_elapsed + 1'b1;
      if (mdl_elapsed > {1'b0, mdl_delay}) begin
        mdl_alarm = !mdl_alarm;
        mdl_armed = 1'b0;
        ev        = EV_TOGGLE;
      end
    end
    res.alarm = mdl_alarm;
    res.armed = mdl_armed;
    res.ev    = ev;
    return res;
  endfunction

  // Driver: predict on acceptance, hold a stalled item, else offer the next
  always @(posedge clk_i or negedge rst_ni) begin
    alarm_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.cmd    = in_cmd;
        it.sample = in_sample;
        predicted_res_q.push_back(alarm_predict(it));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = pending_items_q.pop_front();
          in_valid  <= 1'b1;
          in_cmd    <= it.cmd;
          in_sample <= it.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, started on request from the stimulus
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check accepted result items, drive the output stall
  always @(posedge clk_i) begin
    alarm_res_t exp_res;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_res_q.size() == 0) begin
          $error("result item with nothing expected");
          err_cnt = err_cnt + 1;
        end else begin
          exp_res = predicted_res_q.pop_front();
          if (alarm !== exp_res.alarm) begin
            $error("alarm: expected %0d, actual %0d", exp_res.alarm, alarm);
            err_cnt = err_cnt + 1;
          end
          if (timer_armed !== exp_res.armed) begin
            $error("timer_armed: expected %0d, actual %0d", exp_res.armed, timer_armed);
            err_cnt = err_cnt + 1;
          end
          if (event_res !== exp_res.ev) begin
            $error("event_res: expected %0d, actual %0d", exp_res.ev, event_res);
            err_cnt = err_cnt + 1;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("** delayed_hysteresis_alarm: FAILED **");
      $finish;
    end
  end

  task automatic push_item(cmd_e cmd, logic signed [SampleW-1:0] s);
    alarm_item_t it;
    it.cmd    = cmd;
    it.sample = s;
    pending_items_q.push_back(it);
  endtask

  // Config write; model follows at once since the block is idle
  task automatic write_cfg(logic [1:0] idx, logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SETPOINT:  mdl_setpoint  = data;
      CFG_DELAY:     mdl_delay     = data;
      CFG_DEVIATION: mdl_deviation = data[14:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(int sp, int unsigned dly, int unsigned dev);
    write_cfg(CFG_SETPOINT, sp[15:0]);
    write_cfg(CFG_DELAY, dly[15:0]);
    // top bit beyond the 15-bit band must be ignored
    write_cfg(CFG_DEVIATION, {1'($urandom), dev[14:0]});
  endtask

  // Every expected result back, then a short margin
  task automatic wait_drained();
    while (pending_items_q.size() != 0 || in_valid || predicted_res_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Random items: mostly samples around the band, ticks, some full-range noise
  task automatic add_random_items(int n);
    int span;
    int v;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 40) begin
        push_item(CMD_TICK, SampleW'($urandom));
      end else if ($urandom_range(0, 99) < 10) begin
        push_item(CMD_SAMPLE, SampleW'($urandom));
      end else begin
        span = 2 * int'(mdl_deviation) + 40;
        v = int'(mdl_setpoint) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        push_item(CMD_SAMPLE, v[15:0]);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct <= 15;
    recv_idle_pct <= 47;
    repeat (2) @(posedge clk_i);

    // Reset config: rise, sample while armed, toggle, idle tick, high exit
    push_item(CMD_SAMPLE, 16'sh7fff);
    push_item(CMD_SAMPLE, 16'sd5);
    push_item(CMD_TICK, 16'sh8000);
    push_item(CMD_TICK, 16'sh7fff);
    push_item(CMD_SAMPLE, 16'sh8000);
    push_item(CMD_TICK, 16'sd0);
    push_item(CMD_SAMPLE, 16'sd0);
    push_item(CMD_SAMPLE, -16'sd1);
    wait_drained();

    // Band exit: peak inside the band, sample below the lower edge
    set_cfg(100, 1, 50);
    push_item(CMD_SAMPLE, 16'sd0);
    push_item(CMD_SAMPLE, 16'sd120);
    push_item(CMD_TICK, 16'sd0);
    push_item(CMD_TICK, 16'sd0);
    push_item(CMD_SAMPLE, 16'sd130);
    push_item(CMD_SAMPLE, 16'sd10);
    push_item(CMD_TICK, 16'sd0);
    push_item(CMD_TICK, 16'sd0);
    wait_drained();

    // Extremes: lowest setpoint, widest band, longest delay
    set_cfg(-32768, 65535, 32767);
    push_item(CMD_SAMPLE, 16'sh7fff);
    push_item(CMD_TICK, 16'sd0);
    push_item(CMD_TICK, 16'shffff);
    push_item(CMD_SAMPLE, 16'sh8000);
    push_item(CMD_TICK, 16'sd0);
    add_random_items(60);
    wait_drained();

    // Random phases, sender 15% / receiver 47% idle
    set_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 3), $urandom_range(0, 60));
    add_random_items(300);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    set_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 4), $urandom_range(0, 60));
    add_random_items(300);
    hold_reqs <= hold_reqs + 1;
    wait_drained();

    // Other way round
    send_idle_pct <= 47;
    recv_idle_pct <= 15;
    set_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 4), $urandom_range(0, 80));
    add_random_items(300);
    wait_drained();

    // Highest setpoint, no band
    set_cfg(32767, 0, 0);
    add_random_items(60);
    wait_drained();

    // No idling
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 2), $urandom_range(0, 40));
    add_random_items(300);
    wait_drained();
    set_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 4), $urandom_range(0, 100));
    add_random_items(300);
    wait_drained();

    if (predicted_res_q.size() != 0) begin
      $error("%0d result items never arrived", predicted_res_q.size());
      err_cnt = err_cnt + 1;
    end
    if (err_cnt == 0) begin
      $display("** delayed_hysteresis_alarm: PASSED **");
    end else begin
      $display("** delayed_hysteresis_alarm: FAILED **");
    end
    $finish;
  end

endmodule : tb_delayed_hysteresis_alarm
`default_nettype wire
